@@ src/ddc_pkg.sv @@
// Shared types and codes for the deadlock detection check block.
// Depends on nothing; every other file imports it.
package ddc_pkg;

    // Load item modes.
    localparam logic [1:0] MODE_TOTAL   = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_REQUEST = 2'd2;
    localparam logic [1:0] MODE_CHECK   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_COUNT  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESOURCE_COUNT = 4'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  process_index;
        logic [2:0]  resource_index;
        logic [15:0] amount;
    } in_item_t;

    typedef struct packed {
        logic       is_safe;
        logic [4:0] finished_count;
    } out_item_t;

endpackage

@@ src/deadlock_detection_check_top.sv @@
// Loads: in_ready is high in idle, and load requests are taken one per cycle while idle.
// Check: each process visited takes a scan step, then an address and a compare step per resource tested; one that
// fits then returns its allocation to the work vector; a final scan step and the finish step post the
// result, held while a result waits; the work is serialised by the shared table address and compare.
// Reset: counts go to 1, available and work vectors to zero, finished marks clear;
// the allocation and request tables are not cleared.
// Top level of the deadlock detection check; depends on ddc_pkg.
module deadlock_detection_check_top
    import ddc_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int AMOUNT_BITS   = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AVAIL_BITS = AMOUNT_BITS + 8;
    localparam int DEPTH      = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW         = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CW         = $clog2(MAX_PROCESSES + 1);
    localparam int RCW        = $clog2(MAX_RESOURCES + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_FIT_ADDR = 3'd2;
    localparam logic [2:0] ST_FIT_CMP  = 3'd3;
    localparam logic [2:0] ST_ADD_ADDR = 3'd4;
    localparam logic [2:0] ST_ADD_UPD  = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0]             state_reg;
    logic [4:0]             process_count_reg;
    logic [3:0]             resource_count_reg;
    logic [CW-1:0]          np_reg;
    logic [RCW-1:0]         nr_reg;
    logic [CW-1:0]          pi_reg;
    logic [RCW-1:0]         ri_reg;
    logic [CW-1:0]          done_reg;
    logic [AVAIL_BITS-1:0]  avail_reg [MAX_RESOURCES];
    logic [AVAIL_BITS-1:0]  work_reg [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [AMOUNT_BITS-1:0] alloc_mem [DEPTH];
    logic [AMOUNT_BITS-1:0] req_mem [DEPTH];
    logic [AMOUNT_BITS-1:0] alloc_rdata_reg;
    logic [AMOUNT_BITS-1:0] req_rdata_reg;

    logic                   in_fire;
    logic                   load_p_ok;
    logic                   load_r_ok;
    logic [AMOUNT_BITS-1:0] amt;
    logic [RW-1:0]          load_r;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   alloc_we;
    logic                   req_we;
    logic [CW-1:0]          np_start;
    logic [RCW-1:0]         nr_start;
    logic [RW-1:0]          ri_idx;
    logic [PW-1:0]          pi_idx;
    logic [AVAIL_BITS-1:0]  work_sel;
    logic                   entry_fits;
    logic                   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Decode of a load request.
    assign load_p_ok = 32'(in_data.process_index) < MAX_PROCESSES;
    assign load_r_ok = 32'(in_data.resource_index) < MAX_RESOURCES;
    assign amt       = AMOUNT_BITS'(in_data.amount);
    assign load_r    = RW'(in_data.resource_index);
    assign wr_addr   = AW'(32'(in_data.process_index) * MAX_RESOURCES
                           + 32'(in_data.resource_index));
    assign alloc_we  = in_fire && (in_data.mode == MODE_ALLOC) && load_p_ok && load_r_ok;
    assign req_we    = in_fire && (in_data.mode == MODE_REQUEST) && load_p_ok && load_r_ok;

    // Counts clamped to the table sizes when a check starts.
    assign np_start = (32'(process_count_reg) > MAX_PROCESSES) ? CW'(MAX_PROCESSES)
                                                               : CW'(process_count_reg);
    assign nr_start = (32'(resource_count_reg) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES)
                                                                : RCW'(resource_count_reg);

    // Shared table address and the single compare against the work vector.
    assign pi_idx     = pi_reg[PW-1:0];
    assign ri_idx     = ri_reg[RW-1:0];
    assign rd_addr    = AW'(32'(pi_idx) * MAX_RESOURCES + 32'(ri_idx));
    assign work_sel   = work_reg[ri_idx];
    assign entry_fits = !work_sel[AVAIL_BITS-1] &&
                        (AVAIL_BITS'(req_rdata_reg) <= work_sel);

    // Allocation and request tables with registered reads.
    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[wr_addr] <= amt;
        end
        alloc_rdata_reg <= alloc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req_we)
        begin
            req_mem[wr_addr] <= amt;
        end
        req_rdata_reg <= req_mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg  <= 5'd1;
            resource_count_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PROCESS_COUNT)
            begin
                process_count_reg <= cfg_data[4:0];
            end
            else if (cfg_index == REG_RESOURCE_COUNT)
            begin
                resource_count_reg <= cfg_data[3:0];
            end
        end
    end

    // Sequencer: loads in idle, then scan, fit test and allocation give-back for a check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            np_reg        <= '0;
            nr_reg        <= '0;
            pi_reg        <= '0;
            ri_reg        <= '0;
            done_reg      <= '0;
            finished_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int k = 0; k < MAX_RESOURCES; k++)
            begin
                avail_reg[k] <= '0;
                work_reg[k]  <= '0;
            end
        end
        else
        begin
            // The finish step handles its own hand-off of the result register.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_data.mode)
                            MODE_TOTAL:
                            begin
                                if (load_r_ok)
                                begin
                                    avail_reg[load_r] <= AVAIL_BITS'(amt);
                                end
                            end
                            MODE_ALLOC:
                            begin
                                if (load_r_ok && load_p_ok)
                                begin
                                    avail_reg[load_r] <= avail_reg[load_r] - AVAIL_BITS'(amt);
                                end
                            end
                            MODE_REQUEST:
                            begin
                            end
                            MODE_CHECK:
                            begin
                                for (int k = 0; k < MAX_RESOURCES; k++)
                                begin
                                    work_reg[k] <= avail_reg[k];
                                end
                                finished_reg <= '0;
                                done_reg     <= '0;
                                pi_reg       <= '0;
                                np_reg       <= np_start;
                                nr_reg       <= nr_start;
                                state_reg    <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // Stop when all finished or a full pass found nothing that fits.
                    if (done_reg == np_reg || pi_reg == np_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (finished_reg[pi_idx])
                    begin
                        pi_reg <= pi_reg + 1'b1;
                    end
                    else
                    begin
                        ri_reg    <= '0;
                        state_reg <= ST_FIT_ADDR;
                    end
                end
                ST_FIT_ADDR:
                begin
                    if (ri_reg == nr_reg)
                    begin
                        ri_reg    <= '0;
                        state_reg <= ST_ADD_ADDR;
                    end
                    else
                    begin
                        state_reg <= ST_FIT_CMP;
                    end
                end
                ST_FIT_CMP:
                begin
                    if (entry_fits)
                    begin
                        ri_reg    <= ri_reg + 1'b1;
                        state_reg <= ST_FIT_ADDR;
                    end
                    else
                    begin
                        pi_reg    <= pi_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_ADD_ADDR:
                begin
                    if (ri_reg == nr_reg)
                    begin
                        // Process finishes; the next search starts over at the first row.
                        finished_reg[pi_idx] <= 1'b1;
                        done_reg             <= done_reg + 1'b1;
                        pi_reg               <= '0;
                        state_reg            <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_ADD_UPD;
                    end
                end
                ST_ADD_UPD:
                begin
                    work_reg[ri_idx] <= work_sel + AVAIL_BITS'(alloc_rdata_reg);
                    ri_reg           <= ri_reg + 1'b1;
                    state_reg        <= ST_ADD_ADDR;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.is_safe         <= (done_reg == np_reg);
                        out_data_reg.finished_count  <= 5'(done_reg);
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The finished count never passes the number of processes in the check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (done_reg <= np_reg))
        else $error("finished count exceeds process count");

    // The scan pointer stays within the active rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pi_reg <= np_reg))
        else $error("scan pointer past last process");

    // A compare or an add only happens on an active resource column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIT_CMP || state_reg == ST_ADD_UPD) |-> (ri_reg < nr_reg))
        else $error("resource pointer out of range during compare or add");

    // A check request takes the block out of idle on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.mode == MODE_CHECK) |=> !in_ready)
        else $error("check request did not start the sequencer");

    // A result appears only from the finish step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result posted outside the finish step");

endmodule
